[src/rotation_matrix_to_quaternion_core_macros.svh]
// Assertion macros used by the checker file.
`ifndef ROTATION_MATRIX_TO_QUATERNION_CORE_MACROS_SVH
`define ROTATION_MATRIX_TO_QUATERNION_CORE_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define RMQ_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("rmq assertion failed");

// Condition must never be true outside reset.
`define RMQ_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("rmq forbidden condition seen");

`endif

[src/rmq_pkg.sv]
// Types, constants and step functions for the matrix-to-quaternion pipeline.
package rmq_pkg;

    localparam int SqrtSteps = 15;
    localparam int DivSteps  = 16;

    localparam logic [1:0] BR_TRACE = 2'd0;
    localparam logic [1:0] BR_X     = 2'd1;
    localparam logic [1:0] BR_Y     = 2'd2;
    localparam logic [1:0] BR_Z     = 2'd3;

    localparam logic signed [18:0] ONE_Q14 = 19'sd16384;

    // Item state through the square root stages.
    typedef struct packed {
        logic             bad;
        logic [1:0]       br;
        logic [2:0]       neg;
        logic [2:0][16:0] mag;
        logic [29:0]      x;
        logic [17:0]      rem;
        logic [14:0]      root;
    } sq_t;

    // Item state through the divider stages.
    typedef struct packed {
        logic             bad;
        logic [1:0]       br;
        logic [2:0]       neg;
        logic [14:0]      h;
        logic [2:0]       big;
        logic [2:0][15:0] num;
        logic [2:0][14:0] rem;
        logic [2:0][15:0] q;
    } dv_t;

    // One digit of a radix-2 digit-by-digit square root.
    function automatic sq_t sqrt_step(sq_t a);
        sq_t         r;
        logic [17:0] t;
        logic [17:0] trial;
        r     = a;
        t     = {a.rem[15:0], a.x[29:28]};
        trial = {1'b0, a.root, 2'b01};
        r.x   = {a.x[27:0], 2'b00};
        if (t >= trial) begin
            r.rem  = t - trial;
            r.root = {a.root[13:0], 1'b1};
        end else begin
            r.rem  = t;
            r.root = {a.root[13:0], 1'b0};
        end
        return r;
    endfunction

    // One quotient bit of a restoring divide, three lanes sharing a divisor.
    function automatic dv_t div_step(dv_t a);
        dv_t         r;
        logic [15:0] t;
        r = a;
        for (int k = 0; k < 3; k++) begin
            t        = {a.rem[k], a.num[k][15]};
            r.num[k] = {a.num[k][14:0], 1'b0};
            if (t >= {1'b0, a.h}) begin
                r.rem[k] = 15'(t - {1'b0, a.h});
                r.q[k]   = {a.q[k][14:0], 1'b1};
            end else begin
                r.rem[k] = t[14:0];
                r.q[k]   = {a.q[k][14:0], 1'b0};
            end
        end
        return r;
    endfunction

    // Signed, saturated result from magnitude quotient.
    function automatic logic [15:0] lane_out(logic neg, logic big, logic [15:0] q);
        logic [15:0] v;
        if (!neg) begin
            v = (big || q[15]) ? 16'h7fff : q;
        end else begin
            v = (big || q > 16'h8000) ? 16'h8000 : 16'(-q);
        end
        return v;
    endfunction

endpackage

[src/rotation_matrix_to_quaternion_core.sv]
// Top level: pipelined rotation matrix to unit quaternion converter.
//
// Input channel in_valid/in_ready carries one 3x3 matrix (e11..e33, signed
// Q2.14) per transaction. Output channel out_valid/out_ready carries the
// quaternion qx, qy, qz, qw (signed Q2.14, saturated), branch_used (0 trace
// positive, 1/2/3 x/y/z largest diagonal) and bad_input (root argument not
// positive; all four components then read zero).
// Throughput: one transaction per cycle while out_ready is high. A result passes
// through 35 register stages: decode, operand prep, 15 square root digit
// stages, rounding, 16 divider quotient-bit stages, output register. The
// three off-diagonal terms share each divider stage as three lanes.
// Every stage holds a valid bit; a stage loads when it is empty or its
// successor loads, so bubbles collapse and a stalled receiver backs the
// pipeline up stage by stage with nothing lost or repeated. in_ready drops
// only when every stage holds a transaction.
// Reset (rst_n low, asynchronous) clears all valid bits; payload registers
// are not reset.
module rotation_matrix_to_quaternion_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] e11,
    input  logic signed [15:0] e12,
    input  logic signed [15:0] e13,
    input  logic signed [15:0] e21,
    input  logic signed [15:0] e22,
    input  logic signed [15:0] e23,
    input  logic signed [15:0] e31,
    input  logic signed [15:0] e32,
    input  logic signed [15:0] e33,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] qx,
    output logic signed [15:0] qy,
    output logic signed [15:0] qz,
    output logic signed [15:0] qw,
    output logic [1:0]         branch_used,
    output logic               bad_input
);

    localparam int SqBase  = 2;
    localparam int RndIdx  = SqBase + rmq_pkg::SqrtSteps;
    localparam int DvBase  = RndIdx + 1;
    localparam int OutIdx  = DvBase + rmq_pkg::DivSteps;
    localparam int NStages = OutIdx + 1;

    // Stage valid bits and load enables
    logic [NStages-1:0] v_reg;
    logic [NStages:0]   stage_en;

    always_comb begin
        stage_en[NStages] = out_ready;
        for (int i = NStages - 1; i >= 0; i--) begin
            stage_en[i] = !v_reg[i] || stage_en[i+1];
        end
    end

    assign in_ready = stage_en[0];

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            v_reg <= '0;
        end else begin
            for (int i = 0; i < NStages; i++) begin
                if (stage_en[i]) begin
                    v_reg[i] <= (i == 0) ? in_valid : v_reg[(i == 0) ? 0 : i - 1];
                end
            end
        end
    end

    // Stage 0: branch choice, root argument and off-diagonal terms
    logic signed [17:0] trace;
    logic [1:0]         br_next;
    logic signed [18:0] s_next;
    logic signed [17:0] d0_next, d1_next, d2_next;

    logic [1:0]         br_reg;
    logic signed [18:0] s_reg;
    logic signed [17:0] d_reg [3];

    always_comb begin
        trace = 18'(e11) + 18'(e22) + 18'(e33);
        if (trace > 18'sd0) begin
            br_next = rmq_pkg::BR_TRACE;
            s_next  = rmq_pkg::ONE_Q14 + 19'(e11) + 19'(e22) + 19'(e33);
            d0_next = 18'(e23) - 18'(e32);
            d1_next = 18'(e31) - 18'(e13);
            d2_next = 18'(e12) - 18'(e21);
        end else if (e11 >= e22 && e11 >= e33) begin
            br_next = rmq_pkg::BR_X;
            s_next  = rmq_pkg::ONE_Q14 + 19'(e11) - 19'(e22) - 19'(e33);
            d0_next = 18'(e12) + 18'(e21);
            d1_next = 18'(e13) + 18'(e31);
            d2_next = 18'(e23) - 18'(e32);
        end else if (e22 > e33) begin
            br_next = rmq_pkg::BR_Y;
            s_next  = rmq_pkg::ONE_Q14 + 19'(e22) - 19'(e11) - 19'(e33);
            d0_next = 18'(e21) + 18'(e12);
            d1_next = 18'(e32) + 18'(e23);
            d2_next = 18'(e31) - 18'(e13);
        end else begin
            br_next = rmq_pkg::BR_Z;
            s_next  = rmq_pkg::ONE_Q14 + 19'(e33) - 19'(e11) - 19'(e22);
            d0_next = 18'(e31) + 18'(e13);
            d1_next = 18'(e32) + 18'(e23);
            d2_next = 18'(e12) - 18'(e21);
        end
    end

    always_ff @(posedge clk) begin
        if (stage_en[0]) begin
            br_reg   <= br_next;
            s_reg    <= s_next;
            d_reg[0] <= d0_next;
            d_reg[1] <= d1_next;
            d_reg[2] <= d2_next;
        end
    end

    // Stage 1: sign/magnitude split, radicand S*4096
    rmq_pkg::sq_t prep_next;
    rmq_pkg::sq_t prep_reg;

    always_comb begin
        prep_next.bad = (s_reg <= 19'sd0);
        prep_next.br  = br_reg;
        for (int k = 0; k < 3; k++) begin
            prep_next.neg[k] = d_reg[k][17];
            prep_next.mag[k] = d_reg[k][17] ? 17'(-d_reg[k]) : 17'(d_reg[k]);
        end
        prep_next.x    = {1'b0, s_reg[16:0], 12'b0};
        prep_next.rem  = '0;
        prep_next.root = '0;
    end

    always_ff @(posedge clk) begin
        if (stage_en[1]) begin
            prep_reg <= prep_next;
        end
    end

    // Square root: one digit per stage
    rmq_pkg::sq_t sq_reg [rmq_pkg::SqrtSteps];

    for (genvar j = 0; j < rmq_pkg::SqrtSteps; j++) begin : g_sqrt
        always_ff @(posedge clk) begin
            if (stage_en[SqBase+j]) begin
                if (j == 0) begin
                    sq_reg[j] <= rmq_pkg::sqrt_step(prep_reg);
                end else begin
                    sq_reg[j] <= rmq_pkg::sqrt_step(sq_reg[(j == 0) ? 0 : j - 1]);
                end
            end
        end
    end

    // Round to nearest root, build dividends, flag quotients past 16 bits
    rmq_pkg::sq_t sq_last;
    rmq_pkg::dv_t rnd_next;
    rmq_pkg::dv_t rnd_reg;
    logic [14:0]  h_rnd;
    logic [28:0]  num_full;

    always_comb begin
        sq_last = sq_reg[rmq_pkg::SqrtSteps-1];
        h_rnd   = sq_last.root + 15'(sq_last.rem > 18'(sq_last.root));
        rnd_next.bad = sq_last.bad;
        rnd_next.br  = sq_last.br;
        rnd_next.neg = sq_last.neg;
        rnd_next.h   = h_rnd;
        num_full     = '0;
        for (int k = 0; k < 3; k++) begin
            num_full         = {sq_last.mag[k], 12'b0} + 29'(h_rnd[14:1]);
            rnd_next.big[k]  = {2'b00, num_full} >= {h_rnd, 16'b0};
            rnd_next.num[k]  = num_full[15:0];
            rnd_next.rem[k]  = {2'b00, num_full[28:16]};
            rnd_next.q[k]    = '0;
        end
    end

    always_ff @(posedge clk) begin
        if (stage_en[RndIdx]) begin
            rnd_reg <= rnd_next;
        end
    end

    // Divider: one quotient bit per stage, three lanes
    rmq_pkg::dv_t dv_reg [rmq_pkg::DivSteps];

    for (genvar j = 0; j < rmq_pkg::DivSteps; j++) begin : g_div
        always_ff @(posedge clk) begin
            if (stage_en[DvBase+j]) begin
                if (j == 0) begin
                    dv_reg[j] <= rmq_pkg::div_step(rnd_reg);
                end else begin
                    dv_reg[j] <= rmq_pkg::div_step(dv_reg[(j == 0) ? 0 : j - 1]);
                end
            end
        end
    end

    // Output register: saturate, place components by branch
    rmq_pkg::dv_t dv_last;
    logic [15:0]  c_lane [3];
    logic [15:0]  hc;
    logic [15:0]  qx_next, qy_next, qz_next, qw_next;
    logic [15:0]  qx_reg, qy_reg, qz_reg, qw_reg;
    logic [1:0]   br_out_reg;
    logic         bad_out_reg;

    always_comb begin
        dv_last = dv_reg[rmq_pkg::DivSteps-1];
        hc      = {1'b0, dv_last.h};
        for (int k = 0; k < 3; k++) begin
            c_lane[k] = rmq_pkg::lane_out(dv_last.neg[k], dv_last.big[k], dv_last.q[k]);
        end
        unique case (dv_last.br)
            rmq_pkg::BR_TRACE: begin
                qw_next = hc;        qx_next = c_lane[0];
                qy_next = c_lane[1]; qz_next = c_lane[2];
            end
            rmq_pkg::BR_X: begin
                qx_next = hc;        qy_next = c_lane[0];
                qz_next = c_lane[1]; qw_next = c_lane[2];
            end
            rmq_pkg::BR_Y: begin
                qy_next = hc;        qx_next = c_lane[0];
                qz_next = c_lane[1]; qw_next = c_lane[2];
            end
            default: begin
                qz_next = hc;        qx_next = c_lane[0];
                qy_next = c_lane[1]; qw_next = c_lane[2];
            end
        endcase
        if (dv_last.bad) begin
            qx_next = '0;
            qy_next = '0;
            qz_next = '0;
            qw_next = '0;
        end
    end

    always_ff @(posedge clk) begin
        if (stage_en[OutIdx]) begin
            qx_reg      <= qx_next;
            qy_reg      <= qy_next;
            qz_reg      <= qz_next;
            qw_reg      <= qw_next;
            br_out_reg  <= dv_last.br;
            bad_out_reg <= dv_last.bad;
        end
    end

    assign out_valid   = v_reg[OutIdx];
    assign qx          = qx_reg;
    assign qy          = qy_reg;
    assign qz          = qz_reg;
    assign qw          = qw_reg;
    assign branch_used = br_out_reg;
    assign bad_input   = bad_out_reg;

endmodule

[src/rmq_checker.sv]
// Port-level checker for the matrix-to-quaternion core, bound to the top level.
`include "rotation_matrix_to_quaternion_core_macros.svh"

module rmq_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic signed [15:0] e11,
    input logic signed [15:0] e12,
    input logic signed [15:0] e13,
    input logic signed [15:0] e21,
    input logic signed [15:0] e22,
    input logic signed [15:0] e23,
    input logic signed [15:0] e31,
    input logic signed [15:0] e32,
    input logic signed [15:0] e33,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [15:0] qx,
    input logic signed [15:0] qy,
    input logic signed [15:0] qz,
    input logic signed [15:0] qw,
    input logic [1:0]         branch_used,
    input logic               bad_input
);

    // stalled result holds
    property p_out_hold;
        out_valid && !out_ready |=>
            out_valid && $stable(qx) && $stable(qy) && $stable(qz) && $stable(qw);
    endproperty

    // failed root gives all-zero quaternion
    property p_bad_zero;
        out_valid && bad_input |->
            qx == 16'sd0 && qy == 16'sd0 && qz == 16'sd0 && qw == 16'sd0;
    endproperty

    // in the trace branch the root component qw is strictly positive
    property p_root_pos;
        out_valid && !bad_input && branch_used == rmq_pkg::BR_TRACE |-> qw > 16'sd0;
    endproperty

    `RMQ_ASSERT(a_out_hold, clk, rst_n, p_out_hold)
    `RMQ_ASSERT(a_bad_zero, clk, rst_n, p_bad_zero)
    // positive trace always has a valid root
    `RMQ_NEVER(a_trace_ok, clk, rst_n, out_valid && bad_input && branch_used == rmq_pkg::BR_TRACE)
    `RMQ_ASSERT(a_root_pos, clk, rst_n, p_root_pos)

endmodule

bind rotation_matrix_to_quaternion_core rmq_checker u_rmq_checker (.*);

[test/tb_rotation_matrix_to_quaternion_core.sv]
// Testbench for the matrix-to-quaternion pipeline: directed table, random matrices, scoreboard.
module tb_rotation_matrix_to_quaternion_core;

    localparam int NumRandom = 1700;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [15:0] e11 = '0, e12 = '0, e13 = '0;
    logic signed [15:0] e21 = '0, e22 = '0, e23 = '0;
    logic signed [15:0] e31 = '0, e32 = '0, e33 = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [15:0] qx, qy, qz, qw;
    logic [1:0] branch_used;
    logic bad_input;

    always #6 clk = ~clk;

    rotation_matrix_to_quaternion_core dut (.*);

    typedef struct packed {
        logic signed [15:0] x, y, z, w;
        logic [1:0]         br;
        logic               bad;
    } quat_t;

    typedef logic signed [15:0] mat_t [9];

    quat_t expected_quats[$];
    int    mismatches = 0;
    int    checked = 0;
    int    bad_seen = 0;
    int    branch_seen [4] = '{0, 0, 0, 0};
    bit    sending_done = 0;
    bit    calm = 0;          // last part of the run: no idling
    bit    hold_off = 0;      // long receiver stall in progress

    // Rounded half root: start from real sqrt, then fix up.
    function automatic longint unsigned half_root(longint s);
        longint unsigned v = longint'(s) * 4096;
        longint unsigned r = longint'($sqrt(real'(v)));
        while (r * r > v) r = r - 1;
        while ((r + 1) * (r + 1) <= v) r = r + 1;
        if (v - r * r > r) r = r + 1;
        return r;
    endfunction

    function automatic logic signed [15:0] clamp16(longint v);
        if (v > 32767) return 16'sh7fff;
        if (v < -32768) return -16'sh8000;
        return 16'(v);
    endfunction

    function automatic logic signed [15:0] scaled_term(longint d, longint unsigned h);
        longint unsigned mag = (d < 0) ? longint'(-d) : longint'(d);
        longint unsigned q;
        if (h == 0) return '0;
        q = ((mag << 12) + (h >> 1)) / h;
        if (q > 40000) q = 40000;
        return clamp16((d < 0) ? -longint'(q) : longint'(q));
    endfunction

    function automatic quat_t predict_quat(mat_t m);
        quat_t q;
        longint a11 = m[0], a12 = m[1], a13 = m[2];
        longint a21 = m[3], a22 = m[4], a23 = m[5];
        longint a31 = m[6], a32 = m[7], a33 = m[8];
        longint tr = a11 + a22 + a33;
        longint s, d0, d1, d2;
        longint unsigned h;
        logic signed [15:0] hc, c0, c1, c2;
        q = '{x: '0, y: '0, z: '0, w: '0, br: rmq_pkg::BR_TRACE, bad: 1'b0};
        if (tr > 0) begin
            q.br = rmq_pkg::BR_TRACE; s = 16384 + tr;
            d0 = a23 - a32; d1 = a31 - a13; d2 = a12 - a21;
        end else if (a11 >= a22 && a11 >= a33) begin
            q.br = rmq_pkg::BR_X; s = 16384 + a11 - a22 - a33;
            d0 = a12 + a21; d1 = a13 + a31; d2 = a23 - a32;
        end else if (a22 > a33) begin
            q.br = rmq_pkg::BR_Y; s = 16384 + a22 - a11 - a33;
            d0 = a21 + a12; d1 = a32 + a23; d2 = a31 - a13;
        end else begin
            q.br = rmq_pkg::BR_Z; s = 16384 + a33 - a11 - a22;
            d0 = a31 + a13; d1 = a32 + a23; d2 = a12 - a21;
        end
        if (s <= 0) begin
            q.bad = 1'b1;
            return q;
        end
        h  = half_root(s);
        hc = clamp16(longint'(h));
        c0 = scaled_term(d0, h);
        c1 = scaled_term(d1, h);
        c2 = scaled_term(d2, h);
        case (q.br)
            rmq_pkg::BR_TRACE: begin q.w = hc; q.x = c0; q.y = c1; q.z = c2; end
            rmq_pkg::BR_X:     begin q.x = hc; q.y = c0; q.z = c1; q.w = c2; end
            rmq_pkg::BR_Y:     begin q.y = hc; q.x = c0; q.z = c1; q.w = c2; end
            default:           begin q.z = hc; q.x = c0; q.y = c1; q.w = c2; end
        endcase
        return q;
    endfunction

    // Directed row: matrix, plus a typed-in answer where it is obvious.
    typedef struct {
        mat_t  m;
        bit    known;
        quat_t q;
    } row_t;

    localparam logic signed [15:0] ONE = 16'sd16384;
    localparam logic signed [15:0] MAXV = 16'sh7fff;
    localparam logic signed [15:0] MINV = -16'sh8000;

    row_t directed_rows [$];

    task automatic add_row(mat_t m, bit known, quat_t q);
        row_t r;
        r.m = m; r.known = known; r.q = q;
        directed_rows.push_back(r);
    endtask

    task automatic build_directed();
        quat_t none = '{x: '0, y: '0, z: '0, w: '0, br: rmq_pkg::BR_TRACE, bad: 1'b0};
        // identity: w = 1.0 exactly
        add_row('{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE}, 1,
                '{x: 0, y: 0, z: 0, w: ONE, br: rmq_pkg::BR_TRACE, bad: 1'b0});
        // 180 degrees about x, y, z: pure component, trace -1
        add_row('{ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE}, 1,
                '{x: ONE, y: 0, z: 0, w: 0, br: rmq_pkg::BR_X, bad: 1'b0});
        add_row('{-ONE, 0, 0, 0, ONE, 0, 0, 0, -ONE}, 1,
                '{x: 0, y: ONE, z: 0, w: 0, br: rmq_pkg::BR_Y, bad: 1'b0});
        add_row('{-ONE, 0, 0, 0, -ONE, 0, 0, 0, ONE}, 1,
                '{x: 0, y: 0, z: ONE, w: 0, br: rmq_pkg::BR_Z, bad: 1'b0});
        // all zero: trace 0, tie to x, root of 1.0
        add_row('{0, 0, 0, 0, 0, 0, 0, 0, 0}, 1,
                '{x: 16'sd8192, y: 0, z: 0, w: 0, br: rmq_pkg::BR_X, bad: 1'b0});
        // extreme diagonals: the root argument stays positive
        add_row('{MINV, 0, 0, 0, MAXV, 0, 0, 0, MAXV}, 0, none);
        add_row('{MINV, MAXV, MAXV, MAXV, MINV, MAXV, MAXV, MAXV, MINV}, 0, none);
        add_row('{MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV}, 0, none);
        add_row('{-16'sd16384, 0, 0, 0, -16'sd8192, 0, 0, 0, -16'sd8192}, 0, none);
        add_row('{-16'sd20000, 0, 0, 0, -16'sd8192, 0, 0, 0, -16'sd8192}, 0, none);
        add_row('{-16'sd20000, 0, 0, 0, -16'sd8192, 0, 0, 0, -16'sd100}, 0, none);
        // ties: x wins over y and z, z wins over y
        add_row('{-16'sd100, 5, 6, 7, -16'sd100, 8, 9, 10, -16'sd100}, 0, none);
        add_row('{-16'sd200, 5, 6, 7, -16'sd100, 8, 9, 10, -16'sd100}, 0, none);
        // saturation of off-diagonal terms, both signs
        add_row('{MAXV, MAXV, MINV, MINV, MINV, MAXV, MAXV, MINV, MINV}, 0, none);
        add_row('{MINV, MINV, MAXV, MAXV, MAXV, MINV, MINV, MAXV, MINV}, 0, none);
        add_row('{MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV}, 0, none);
        add_row('{MINV, MAXV, MINV, MAXV, MINV, MAXV, MINV, MAXV, MAXV}, 0, none);
        add_row('{16'sd1, -16'sd1, 16'sd1, -16'sd1, 16'sd0, 16'sd1, -16'sd1, 16'sd1, 16'sd0},
                0, none);
        // 90 degrees about z, then 90 degrees about y
        add_row('{0, -ONE, 0, ONE, 0, 0, 0, 0, ONE}, 0, none);
        add_row('{0, 0, ONE, 0, ONE, 0, -ONE, 0, 0}, 0, none);
    endtask

    // Random rotation-like matrix (random axis/angle) or raw noise.
    function automatic mat_t random_matrix();
        mat_t m;
        real qa, qb, qc, qd, n;
        int kind = $urandom_range(0, 9);
        if (kind < 7) begin
            qa = real'($urandom_range(0, 2000)) - 1000.0;
            qb = real'($urandom_range(0, 2000)) - 1000.0;
            qc = real'($urandom_range(0, 2000)) - 1000.0;
            qd = real'($urandom_range(0, 2000)) - 1000.0;
            n = $sqrt(qa*qa + qb*qb + qc*qc + qd*qd);
            if (n < 1.0) begin qd = 1.0; n = 1.0; end
            qa /= n; qb /= n; qc /= n; qd /= n;   // x y z w
            m[0] = 16'($rtoi(16384.0 * (1.0 - 2.0*(qb*qb + qc*qc))));
            m[1] = 16'($rtoi(16384.0 * (2.0*(qa*qb - qc*qd))));
            m[2] = 16'($rtoi(16384.0 * (2.0*(qa*qc + qb*qd))));
            m[3] = 16'($rtoi(16384.0 * (2.0*(qa*qb + qc*qd))));
            m[4] = 16'($rtoi(16384.0 * (1.0 - 2.0*(qa*qa + qc*qc))));
            m[5] = 16'($rtoi(16384.0 * (2.0*(qb*qc - qa*qd))));
            m[6] = 16'($rtoi(16384.0 * (2.0*(qa*qc - qb*qd))));
            m[7] = 16'($rtoi(16384.0 * (2.0*(qb*qc + qa*qd))));
            m[8] = 16'($rtoi(16384.0 * (1.0 - 2.0*(qa*qa + qb*qb))));
            // small jitter
            foreach (m[i]) m[i] = m[i] + 16'(int'($urandom_range(0, 8)) - 4);
        end else if (kind < 9) begin
            foreach (m[i]) m[i] = 16'($urandom);
        end else begin
            foreach (m[i]) m[i] = 16'(int'($urandom_range(0, 4000)) - 2000);
        end
        return m;
    endfunction

    task automatic idle_burst();
        if (!calm && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 10)) @(negedge clk);
    endtask

    // Offer one matrix and wait for the transaction to complete.
    task automatic send_matrix(mat_t m, bit known, quat_t q);
        quat_t p;
        p = predict_quat(m);
        if (known && p != q)
            $display("note: table row disagrees with predictor, table used");
        expected_quats.push_back(known ? q : p);
        {e11, e12, e13, e21, e22, e23, e31, e32, e33} =
            {m[0], m[1], m[2], m[3], m[4], m[5], m[6], m[7], m[8]};
        in_valid = 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    // Stimulus
    initial begin
        mat_t m;
        quat_t none;
        none = '{x: '0, y: '0, z: '0, w: '0, br: rmq_pkg::BR_TRACE, bad: 1'b0};
        build_directed();
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        foreach (directed_rows[i]) begin
            send_matrix(directed_rows[i].m, directed_rows[i].known, directed_rows[i].q);
            idle_burst();
        end
        for (int i = 0; i < NumRandom; i++) begin
            if (i == NumRandom - 300) calm = 1;
            m = random_matrix();
            send_matrix(m, 0, none);
            idle_burst();
        end
        sending_done = 1;
    end

    // Receiver: random stall bursts plus one long hold-off early on.
    initial begin
        int n;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (checked == 40 && !hold_off) begin
                hold_off = 1;
                out_ready = 1'b0;
                n = 0;
                while (n < 300) begin
                    @(negedge clk);
                    n++;
                end
            end
            if (!calm && $urandom_range(0, 4) == 0) begin
                out_ready = 1'b0;
                n = $urandom_range(1, 10);
                repeat (n - 1) @(negedge clk);
            end else begin
                out_ready = 1'b1;
            end
        end
    end

    // Checker: sample at the rising edge.
    always @(posedge clk) begin
        quat_t e;
        if (rst_n && out_valid && out_ready) begin
            if (expected_quats.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected quaternion transaction");
            end else begin
                e = expected_quats.pop_front();
                checked++;
                branch_seen[branch_used]++;
                if (bad_input) bad_seen++;
                if (qx !== e.x || qy !== e.y || qz !== e.z || qw !== e.w
                    || branch_used !== e.br || bad_input !== e.bad) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch #%0d: exp x=%0d y=%0d z=%0d w=%0d br=%0d bad=%0d",
                                 checked, e.x, e.y, e.z, e.w, e.br, e.bad,
                                 " got x=%0d y=%0d z=%0d w=%0d br=%0d bad=%0d",
                                 qx, qy, qz, qw, branch_used, bad_input);
                end
            end
        end
    end

    // End of run
    initial begin
        wait (sending_done);
        while (expected_quats.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        $display("checked %0d quaternions: branches %0d/%0d/%0d/%0d, bad input %0d",
                 checked, branch_seen[0], branch_seen[1], branch_seen[2], branch_seen[3],
                 bad_seen);
        $display("mismatches: %0d", mismatches);
        if (mismatches == 0 && expected_quats.size() == 0)
            $display("[rotation_matrix_to_quaternion_core] OK");
        else
            $display("[rotation_matrix_to_quaternion_core] ERROR");
        $finish;
    end

    // Watchdog
    initial begin
        #3000000;
        $display("[rotation_matrix_to_quaternion_core] ERROR");
        $finish;
    end
endmodule
